// ===== hw/rtl/tvb_minmod_slope_limiter_top_defines.svh =====
// ----------------------------------------------------------------------------
// TVB minmod slope limiter: assertion macros
// Shared concurrent assertion forms; expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TVB_MINMOD_SLOPE_LIMITER_TOP_DEFINES_SVH
`define TVB_MINMOD_SLOPE_LIMITER_TOP_DEFINES_SVH

// same-cycle implication
`define TVB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TVB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tvb_mm_pkg.sv =====
// ----------------------------------------------------------------------------
// TVB minmod slope limiter package
// Types, register codes and sizing helpers shared by the limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tvb_mm_pkg;

    localparam int NUM_LANES = 3;
    localparam int MUL_CHUNK = 16;

    localparam int SCALE_W   = 21;
    localparam int BOUND_W   = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SLOPE_BOUND = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 21'd65536;
    localparam logic [BOUND_W-1:0] BOUND_RESET = 31'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_AVG,
        S_HOLD,
        S_DIFF,
        S_MUL,
        S_EMIT_HELD,
        S_EMIT_CUR
    } t_state;

    typedef struct packed {
        logic cur_load;
        logic div_step;
        logic avg_load;
        logic diff_load;
        logic mul_step;
        logic hold_load;
        logic before_load;
        logic sel_cur;
        logic edge_cell;
    } t_lane_ctrl;

    // chunks of (|curv| + 6) >> 2 multiplied by the reciprocal of 3
    function automatic int div_steps(int coef_w);
        return (coef_w - 2 + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

    // chunks of the difference magnitude (coef_w + 1 bits)
    function automatic int mul_steps(int coef_w);
        return (coef_w + 1 + MUL_CHUNK - 1) / MUL_CHUNK;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tvb_mm_lane.sv =====
// ----------------------------------------------------------------------------
// TVB minmod lane
// One field of a cell: average, neighbor differences and limited output.
// ----------------------------------------------------------------------------
`default_nettype none

module tvb_mm_lane #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire tvb_mm_pkg::t_lane_ctrl             i_ctrl,
    input  wire logic signed [COEF_WIDTH-1:0]       i_mean,
    input  wire logic signed [COEF_WIDTH-1:0]       i_slope,
    input  wire logic signed [COEF_WIDTH-1:0]       i_curv,
    input  wire logic [tvb_mm_pkg::SCALE_W-1:0]     i_scale,
    input  wire logic [tvb_mm_pkg::BOUND_W-1:0]     i_bound,
    output logic signed [COEF_WIDTH-1:0]            o_mean,
    output logic signed [COEF_WIDTH-1:0]            o_slope,
    output logic signed [COEF_WIDTH-1:0]            o_curv
);
    import tvb_mm_pkg::*;

    localparam int W         = COEF_WIDTH;
    localparam int YW        = W - 2;
    localparam int DIV_STEPS = div_steps(W);
    localparam int DQ_W      = DIV_STEPS * MUL_CHUNK;
    localparam int RCP_W     = W - 1;
    localparam int QA_W      = DQ_W + RCP_W;
    localparam int DM_W      = W + 1;
    localparam int MP_W      = mul_steps(W) * MUL_CHUNK;
    localparam int ACC_W     = MP_W + SCALE_W;
    localparam int MW        = ACC_W + 1 - FRAC_BITS;
    localparam int CW        = W + BOUND_W + MW;

    localparam logic signed [W+1:0] SMAX = $signed({3'b000, {(W-1){1'b1}}});
    localparam logic signed [W+1:0] SMIN = -SMAX - 1;
    localparam logic [ACC_W:0]      HALF = (ACC_W+1)'(1) << (FRAC_BITS - 1);

    // ceil(2^W / 3): exact floor(y / 3) as (y * RCP3) >> W for y below 2^(W-2)
    localparam logic [W+1:0]     RCP_FULL = (((W+2)'(1) << W) + (W+2)'(2)) / (W+2)'(3);
    localparam logic [RCP_W-1:0] RCP3     = RCP_W'(RCP_FULL);

    logic signed [W-1:0] r_mean, r_slope, r_curv, r_cur_avg;
    logic signed [W-1:0] r_h_mean, r_h_slope, r_h_curv, r_h_avg, r_b_avg;
    logic                r_neg;
    logic [DQ_W-1:0]     r_dq;
    logic [QA_W-1:0]     r_qacc;
    logic [MP_W-1:0]     r_dm_l, r_dm_r;
    logic                r_neg_l, r_neg_r;
    logic [ACC_W-1:0]    r_acc_l, r_acc_r;

    // quotient load
    logic [W-1:0]  c_abs, c_abs6;
    logic [YW-1:0] c_y;

    assign c_abs  = i_curv[W-1] ? W'(-i_curv) : W'(i_curv);
    assign c_abs6 = c_abs + W'(6);
    assign c_y    = c_abs6[W-1:2];

    // reciprocal multiply, MSB chunk first
    logic [MUL_CHUNK+RCP_W-1:0] q_p;

    assign q_p = r_dq[DQ_W-1 -: MUL_CHUNK] * RCP3;

    // average with saturation
    logic signed [W+1:0] q_s, a_sum;
    logic signed [W-1:0] a_sat;

    assign q_s   = $signed((W+2)'(r_qacc[QA_W-1:W]));
    assign a_sum = (W+2)'(r_mean) + (r_neg ? -q_s : q_s);
    always_comb begin
        if (a_sum > SMAX) begin
            a_sat = W'(SMAX);
        end else if (a_sum < SMIN) begin
            a_sat = W'(SMIN);
        end else begin
            a_sat = W'(a_sum);
        end
    end

    // neighbor differences
    logic signed [W:0] d_l, d_r;
    logic [DM_W-1:0]   dm_l, dm_r;

    assign d_l  = (W+1)'(r_h_avg) - (W+1)'(r_b_avg);
    assign d_r  = (W+1)'(r_cur_avg) - (W+1)'(r_h_avg);
    assign dm_l = d_l[W] ? DM_W'(-d_l) : DM_W'(d_l);
    assign dm_r = d_r[W] ? DM_W'(-d_r) : DM_W'(d_r);

    // chunked multiply, MSB chunk first
    logic [MUL_CHUNK+SCALE_W-1:0] p_l, p_r;

    assign p_l = r_dm_l[MP_W-1 -: MUL_CHUNK] * i_scale;
    assign p_r = r_dm_r[MP_W-1 -: MUL_CHUNK] * i_scale;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cur_load) begin
            r_mean  <= i_mean;
            r_slope <= i_slope;
            r_curv  <= i_curv;
            r_neg   <= i_curv[W-1];
            r_dq    <= DQ_W'(c_y);
            r_qacc  <= '0;
        end else if (i_ctrl.div_step) begin
            r_dq   <= r_dq << MUL_CHUNK;
            r_qacc <= (r_qacc << MUL_CHUNK) + QA_W'(q_p);
        end
        if (i_ctrl.avg_load) begin
            r_cur_avg <= a_sat;
        end
        if (i_ctrl.diff_load) begin
            r_dm_l  <= MP_W'(dm_l);
            r_dm_r  <= MP_W'(dm_r);
            r_neg_l <= d_l[W];
            r_neg_r <= d_r[W];
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (i_ctrl.mul_step) begin
            r_dm_l  <= r_dm_l << MUL_CHUNK;
            r_dm_r  <= r_dm_r << MUL_CHUNK;
            r_acc_l <= (r_acc_l << MUL_CHUNK) + ACC_W'(p_l);
            r_acc_r <= (r_acc_r << MUL_CHUNK) + ACC_W'(p_r);
        end
        if (i_ctrl.hold_load) begin
            r_h_mean  <= r_mean;
            r_h_slope <= r_slope;
            r_h_curv  <= r_curv;
            r_h_avg   <= r_cur_avg;
        end
        if (i_ctrl.before_load) begin
            r_b_avg <= r_h_avg;
        end
    end

    // rounded scaled difference magnitudes
    logic [ACC_W:0] rd_l, rd_r;
    logic [MW-1:0]  m_l, m_r;

    assign rd_l = (ACC_W+1)'(r_acc_l) + HALF;
    assign rd_r = (ACC_W+1)'(r_acc_r) + HALF;
    assign m_l  = rd_l[ACC_W:FRAC_BITS];
    assign m_r  = rd_r[ACC_W:FRAC_BITS];

    // limiter on the selected cell
    logic signed [W-1:0] s_mean, s_slope, s_curv, s_avg, lim;
    logic                s_neg, keep, mm_ok, changed;
    logic [W-1:0]        s_abs, mn_w;
    logic [CW-1:0]       mn;

    assign s_mean  = i_ctrl.sel_cur ? r_mean    : r_h_mean;
    assign s_slope = i_ctrl.sel_cur ? r_slope   : r_h_slope;
    assign s_curv  = i_ctrl.sel_cur ? r_curv    : r_h_curv;
    assign s_avg   = i_ctrl.sel_cur ? r_cur_avg : r_h_avg;
    assign s_neg   = s_slope[W-1];
    assign s_abs   = s_neg ? W'(-s_slope) : W'(s_slope);
    assign keep    = CW'(s_abs) <= CW'(i_bound);
    assign mm_ok   = (m_l != '0) && (m_r != '0) && (r_neg_l == s_neg) && (r_neg_r == s_neg);

    always_comb begin
        mn = CW'(s_abs);
        if (CW'(m_l) < mn) begin
            mn = CW'(m_l);
        end
        if (CW'(m_r) < mn) begin
            mn = CW'(m_r);
        end
    end

    assign mn_w = mn[W-1:0];

    always_comb begin
        if (keep) begin
            lim = s_slope;
        end else if (i_ctrl.edge_cell || !mm_ok) begin
            lim = '0;
        end else begin
            lim = s_neg ? $signed(-mn_w) : $signed(mn_w);
        end
    end

    assign changed = lim != s_slope;
    assign o_mean  = changed ? s_avg : s_mean;
    assign o_slope = lim;
    assign o_curv  = changed ? '0 : s_curv;

endmodule

`default_nettype wire

// ===== hw/rtl/tvb_mm_ctrl.sv =====
// ----------------------------------------------------------------------------
// TVB minmod sequencer
// Steps each cell through divide, multiply and emit phases; tracks the window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tvb_minmod_slope_limiter_top_defines.svh"

module tvb_mm_ctrl #(
    parameter int COEF_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tlast,
    input  wire logic                   i_out_free,
    output logic                        o_s_tready,
    output tvb_mm_pkg::t_lane_ctrl      o_ctrl,
    output logic                        o_out_load,
    output logic                        o_out_last
);
    import tvb_mm_pkg::*;

    localparam int DIV_STEPS = div_steps(COEF_WIDTH);
    localparam int MUL_STEPS = mul_steps(COEF_WIDTH);
    localparam int MAX_STEPS = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_have_held, n_have_held;
    logic             r_first, n_first;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have_held <= 1'b0;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have_held <= n_have_held;
            r_first     <= n_first;
            if (i_s_tvalid && o_s_tready) begin
                r_last <= i_s_tlast;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_have_held = r_have_held;
        n_first     = r_first;
        o_s_tready  = 1'b0;
        o_ctrl      = '0;
        o_out_load  = 1'b0;
        o_out_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.cur_load = 1'b1;
                    n_cnt           = CNT_W'(DIV_STEPS - 1);
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_AVG;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_AVG: begin
                o_ctrl.avg_load = 1'b1;
                if (!r_have_held) begin
                    n_state = r_last ? S_EMIT_CUR : S_HOLD;
                end else if (r_first) begin
                    n_state = S_EMIT_HELD;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_HOLD: begin
                o_ctrl.hold_load = 1'b1;
                n_have_held      = 1'b1;
                n_first          = 1'b1;
                n_state          = S_IDLE;
            end
            S_DIFF: begin
                o_ctrl.diff_load = 1'b1;
                n_cnt            = CNT_W'(MUL_STEPS - 1);
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_ctrl.mul_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_EMIT_HELD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_EMIT_HELD: begin
                o_ctrl.edge_cell = r_first;
                if (i_out_free) begin
                    o_out_load         = 1'b1;
                    o_ctrl.before_load = 1'b1;
                    n_first            = 1'b0;
                    if (r_last) begin
                        n_have_held = 1'b0;
                        n_state     = S_EMIT_CUR;
                    end else begin
                        o_ctrl.hold_load = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_EMIT_CUR: begin
                o_ctrl.sel_cur   = 1'b1;
                o_ctrl.edge_cell = 1'b1;
                o_out_last       = 1'b1;
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `TVB_ASSERT_IMP(a_load_free, o_out_load, i_out_free, "result loaded over a waiting result")
    `TVB_ASSERT_IMP(a_held_present, (r_state == S_DIFF) || (r_state == S_MUL) || (r_state == S_EMIT_HELD), r_have_held, "neighbor phase without a held cell")
    `TVB_ASSERT_NXT(a_one_cell, i_s_tvalid && o_s_tready, !o_s_tready, "second transfer taken while a cell is in work")

endmodule

`default_nettype wire

// ===== hw/rtl/tvb_mm_merge.sv =====
// ----------------------------------------------------------------------------
// TVB minmod output merge
// Packs the three lane results into one output register and drives the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tvb_mm_merge #(
    parameter  int COEF_WIDTH = 32,
    localparam int TDATA_W    = ((3 * tvb_mm_pkg::NUM_LANES * COEF_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic                         i_last,
    input  wire logic signed [COEF_WIDTH-1:0] i_mean  [tvb_mm_pkg::NUM_LANES],
    input  wire logic signed [COEF_WIDTH-1:0] i_slope [tvb_mm_pkg::NUM_LANES],
    input  wire logic signed [COEF_WIDTH-1:0] i_curv  [tvb_mm_pkg::NUM_LANES],
    input  wire logic                         i_m_tready,
    output logic                              o_free,
    output logic                              o_m_tvalid,
    output logic                              o_m_tlast,
    output logic [TDATA_W-1:0]                o_m_tdata
);
    import tvb_mm_pkg::*;

    localparam int W = COEF_WIDTH;

    logic               r_valid;
    logic               r_last;
    logic [TDATA_W-1:0] r_data, n_data;

    always_comb begin
        n_data = '0;
        for (int f = 0; f < NUM_LANES; f++) begin
            n_data[(3*f)*W   +: W] = i_mean[f];
            n_data[(3*f+1)*W +: W] = i_slope[f];
            n_data[(3*f+2)*W +: W] = i_curv[f];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
            r_last <= i_last;
        end
    end

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

// ===== hw/rtl/tvb_minmod_slope_limiter_top.sv =====
// ----------------------------------------------------------------------------
// TVB minmod slope limiter
// Cells enter one transfer at a time and are limited one cell behind, once
// both neighbors are known. Each cell runs the per-lane divide by 12 (a
// reciprocal-of-3 multiply of (|curv|+6)/4, 16 bits per cycle); when the held
// cell is interior, the chunked neighbor-scale multiply (16 bits of the
// difference per cycle) follows before it is emitted. A last cell is emitted
// after the held cell, or alone in a single-cell line. A result that waits
// on the output stalls the emit cycle. The output register lets the next
// cell enter while a result waits. There is no clearing pass after reset.
// Configuration: index 0 neighbor_scale, index 1 small_slope_bound; write
// only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tvb_minmod_slope_limiter_top #(
    parameter  int COEF_WIDTH = 32,
    parameter  int FRAC_BITS  = 16,
    localparam int TDATA_W    = ((3 * tvb_mm_pkg::NUM_LANES * COEF_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // mass_mean, mass_slope, mass_curv, momentum_mean, momentum_slope,
    // momentum_curv, energy_mean, energy_slope, energy_curv, zero pad
    input  wire logic [TDATA_W-1:0]             i_s_tdata,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tlast,
    output logic                                o_s_tready,
    // out_mass_mean, out_mass_slope, out_mass_curv, out_momentum_mean,
    // out_momentum_slope, out_momentum_curv, out_energy_mean,
    // out_energy_slope, out_energy_curv, zero pad
    output logic [TDATA_W-1:0]                  o_m_tdata,
    output logic                                o_m_tvalid,
    output logic                                o_m_tlast,
    input  wire logic                           i_m_tready,
    input  wire logic                           i_cfg_we,
    input  wire logic [tvb_mm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tvb_mm_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import tvb_mm_pkg::*;

    localparam int W = COEF_WIDTH;

    logic [SCALE_W-1:0] r_scale;
    logic [BOUND_W-1:0] r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_bound <= BOUND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEIGHBOR_SCALE:    r_scale <= i_cfg_wdata[SCALE_W-1:0];
                CFG_SMALL_SLOPE_BOUND: r_bound <= i_cfg_wdata[BOUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    t_lane_ctrl          w_ctrl;
    logic                w_out_load, w_out_last, w_out_free;
    logic signed [W-1:0] w_mean  [NUM_LANES];
    logic signed [W-1:0] w_slope [NUM_LANES];
    logic signed [W-1:0] w_curv  [NUM_LANES];

    tvb_mm_ctrl #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_out_free (w_out_free),
        .o_s_tready (o_s_tready),
        .o_ctrl     (w_ctrl),
        .o_out_load (w_out_load),
        .o_out_last (w_out_last)
    );

    for (genvar f = 0; f < NUM_LANES; f++) begin : g_lane
        tvb_mm_lane #(
            .COEF_WIDTH (COEF_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_mean  ($signed(i_s_tdata[(3*f)*W   +: W])),
            .i_slope ($signed(i_s_tdata[(3*f+1)*W +: W])),
            .i_curv  ($signed(i_s_tdata[(3*f+2)*W +: W])),
            .i_scale (r_scale),
            .i_bound (r_bound),
            .o_mean  (w_mean[f]),
            .o_slope (w_slope[f]),
            .o_curv  (w_curv[f])
        );
    end

    tvb_mm_merge #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_out_load),
        .i_last     (w_out_last),
        .i_mean     (w_mean),
        .i_slope    (w_slope),
        .i_curv     (w_curv),
        .i_m_tready (i_m_tready),
        .o_free     (w_out_free),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tlast  (o_m_tlast),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
